/* sv/ssq_pkg.sv */
// Shared types, codes and constants of the stable sorted priority queue.
package ssq_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int KEY_W      = 16;
    localparam int TIME_W     = 17;
    localparam int PAY_PORT_W = 32;
    localparam int STATUS_W   = 2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_POP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL_PUSH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_CMP,
        S_INS,
        S_DONE
    } t_state;

    // Status part of a finished result, handed from the controller to the output stage.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                empty_after;
    } t_result;

endpackage

/* sv/ssq_mem.sv */
// Entry memory: one write port and one read port with registered read data.
module ssq_mem #(
    parameter int DEPTH  = ssq_pkg::DEPTH_DEF,
    parameter int DATA_W = ssq_pkg::KEY_W + ssq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ssq_ctrl.sv */
// Queue controller: ring pointers, ordered-insert walk and pop sequencing.
module ssq_ctrl #(
    parameter int DEPTH = ssq_pkg::DEPTH_DEF,
    parameter int PW    = ssq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [ssq_pkg::KEY_W-1:0]   i_key_time,
    input  logic [PW-1:0]               i_pay,
    input  logic                        i_out_free,
    output logic                        o_res_valid,
    output ssq_pkg::t_result            o_res,
    output logic [ssq_pkg::TIME_W-1:0]  o_res_time,
    output logic [PW-1:0]               o_res_pay,
    output logic                        o_mem_we,
    output logic [$clog2(DEPTH)-1:0]    o_mem_waddr,
    output logic [ssq_pkg::KEY_W+PW-1:0] o_mem_wdata,
    output logic                        o_mem_re,
    output logic [$clog2(DEPTH)-1:0]    o_mem_raddr,
    input  logic [ssq_pkg::KEY_W+PW-1:0] i_mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = ssq_pkg::KEY_W;
    localparam int TW = ssq_pkg::TIME_W;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
    endfunction

    ssq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [AW-1:0]    r_wpos, n_wpos;
    logic [AW-1:0]    r_raddr, n_raddr;
    logic [CW-1:0]    r_left, n_left;
    logic [KW-1:0]    r_key, n_key;
    logic [PW-1:0]    r_pay, n_pay;
    ssq_pkg::t_result r_res, n_res;
    logic [TW-1:0]    r_res_time, n_res_time;
    logic [PW-1:0]    r_res_pay, n_res_pay;

    logic [KW-1:0]    rd_key;
    logic [PW-1:0]    rd_pay;

    assign rd_key = i_mem_rdata[KW+PW-1:PW];
    assign rd_pay = i_mem_rdata[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssq_pkg::S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wpos     <= n_wpos;
        r_raddr    <= n_raddr;
        r_left     <= n_left;
        r_key      <= n_key;
        r_pay      <= n_pay;
        r_res      <= n_res;
        r_res_time <= n_res_time;
        r_res_pay  <= n_res_pay;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_wpos      = r_wpos;
        n_raddr     = r_raddr;
        n_left      = r_left;
        n_key       = r_key;
        n_pay       = r_pay;
        n_res       = r_res;
        n_res_time  = r_res_time;
        n_res_pay   = r_res_pay;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wpos;
        o_mem_wdata = {r_key, r_pay};
        o_mem_re    = 1'b0;
        o_mem_raddr = r_raddr;

        unique case (r_state)
            ssq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_res_time = '0;
                    n_res_pay  = '0;
                    if (i_mode == ssq_pkg::MODE_PUSH) begin
                        n_res.empty_after = 1'b0;
                        if (r_count == CW'(DEPTH)) begin
                            n_res.status = ssq_pkg::ST_FULL_PUSH;
                            n_state      = ssq_pkg::S_DONE;
                        end else begin
                            n_res.status = ssq_pkg::ST_OK;
                            n_key        = i_key_time;
                            n_pay        = i_pay;
                            n_tail       = f_next(r_tail);
                            n_count      = r_count + CW'(1);
                            if (r_count == '0) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_tail;
                                o_mem_wdata = {i_key_time, i_pay};
                                n_state     = ssq_pkg::S_DONE;
                            end else begin
                                // Walk back from the tail, one stored entry per cycle.
                                o_mem_re    = 1'b1;
                                o_mem_raddr = f_prev(r_tail);
                                n_raddr     = f_prev(r_tail);
                                n_wpos      = r_tail;
                                n_left      = r_count;
                                n_state     = ssq_pkg::S_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status      = ssq_pkg::ST_EMPTY_POP;
                            n_res.empty_after = 1'b1;
                            n_res_time        = '1;
                            n_state           = ssq_pkg::S_DONE;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = r_head;
                            n_state     = ssq_pkg::S_POP_RD;
                        end
                    end
                end
            end
            ssq_pkg::S_POP_RD: begin
                n_res.status      = ssq_pkg::ST_OK;
                n_res.empty_after = (r_count == CW'(1));
                n_res_time        = {1'b0, rd_key};
                n_res_pay         = rd_pay;
                n_head            = f_next(r_head);
                n_count           = r_count - CW'(1);
                n_state           = ssq_pkg::S_DONE;
            end
            ssq_pkg::S_CMP: begin
                o_mem_we = 1'b1;
                if (rd_key > r_key) begin
                    // Strictly larger key moves up one slot; equal keys stay ahead.
                    o_mem_waddr = r_wpos;
                    o_mem_wdata = i_mem_rdata;
                    n_wpos      = r_raddr;
                    n_left      = r_left - CW'(1);
                    if (r_left != CW'(1)) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = f_prev(r_raddr);
                        n_raddr     = f_prev(r_raddr);
                    end else begin
                        n_state = ssq_pkg::S_INS;
                    end
                end else begin
                    n_state = ssq_pkg::S_DONE;
                end
            end
            ssq_pkg::S_INS: begin
                o_mem_we = 1'b1;
                n_state  = ssq_pkg::S_DONE;
            end
            ssq_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_out_free) begin
                    n_state = ssq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res      = r_res;
    assign o_res_time = r_res_time;
    assign o_res_pay  = r_res_pay;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssq_pkg::S_CMP |-> r_left != '0)
        else $error("insert walk running with no entries left");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> o_mem_waddr != o_mem_raddr)
        else $error("read and write hit the same entry");

    a_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssq_pkg::S_IDLE && r_head == r_tail)
            |-> (r_count == '0 || r_count == CW'(DEPTH)))
        else $error("ring pointers disagree with entry count");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssq_pkg::S_POP_RD |-> r_count != '0)
        else $error("pop read issued on empty queue");

endmodule

/* sv/stable_sorted_priority_queue_unit.sv */
// A push into a non-empty queue moves every stored entry with a larger key back a slot before
// its result waits; a pop reads the head entry, and a push into an empty queue, a push to a full
// queue or a pop of an empty one finishes without a walk. The ordered insert walks the entry
// memory one entry per cycle from the tail, reading the next entry while writing the previous
// one back a slot. Entries sit in a ring, so a pop only moves the head. Results go through an
// output register, so a new item is taken while the previous result still waits; the block
// works on one item at a time.
module stable_sorted_priority_queue_unit #(
    parameter int DEPTH        = ssq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = ssq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [ssq_pkg::KEY_W-1:0]           i_key_time,
    input  logic [ssq_pkg::PAY_PORT_W-1:0]      i_payload,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ssq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [ssq_pkg::TIME_W-1:0]   o_out_time,
    output logic [ssq_pkg::PAY_PORT_W-1:0]      o_out_payload,
    output logic                                o_empty_after
);

    // Only the payload bits that the port can carry are stored.
    localparam int PW = (PAYLOAD_BITS < ssq_pkg::PAY_PORT_W) ? PAYLOAD_BITS
                                                             : ssq_pkg::PAY_PORT_W;
    localparam int AW = $clog2(DEPTH);
    localparam int DW = ssq_pkg::KEY_W + PW;

    logic                         out_free;
    logic                         res_valid;
    ssq_pkg::t_result             res;
    logic [ssq_pkg::TIME_W-1:0]   res_time;
    logic [PW-1:0]                res_pay;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [DW-1:0]                mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [DW-1:0]                mem_rdata;

    logic                         r_out_valid;
    ssq_pkg::t_result             r_out_res;
    logic [ssq_pkg::TIME_W-1:0]   r_out_time;
    logic [PW-1:0]                r_out_pay;

    assign out_free = !r_out_valid || i_out_ready;

    ssq_ctrl #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_key_time  (i_key_time),
        .i_pay       (i_payload[PW-1:0]),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_res_time  (res_time),
        .o_res_pay   (res_pay),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ssq_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out_res  <= res;
            r_out_time <= res_time;
            r_out_pay  <= res_pay;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_res.status;
    assign o_empty_after = r_out_res.empty_after;
    assign o_out_time    = r_out_time;
    assign o_out_payload = ssq_pkg::PAY_PORT_W'(r_out_pay);

endmodule

/* tb/tb_stable_sorted_priority_queue_unit.sv */
// Self-checking testbench of the stable sorted priority queue unit.
module tb_stable_sorted_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W      = ssq_pkg::KEY_W;
    localparam int TIME_W     = ssq_pkg::TIME_W;
    localparam int PAY_PORT_W = ssq_pkg::PAY_PORT_W;
    localparam int STATUS_W   = ssq_pkg::STATUS_W;

    localparam int QDEPTH         = ssq_pkg::DEPTH_DEF;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 525;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SHOWN_ERRORS   = 10;
    localparam logic [PAY_PORT_W-1:0] PAY_MASK =
        (ssq_pkg::PAYLOAD_BITS_DEF >= PAY_PORT_W) ? '1
            : ((32'd1 << ssq_pkg::PAYLOAD_BITS_DEF) - 32'd1);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [TIME_W-1:0] otime;
        logic [PAY_PORT_W-1:0]    opay;
        logic                     empty;
    } t_resp;

    typedef struct packed {
        logic                  mode;
        logic [KEY_W-1:0]      key;
        logic [PAY_PORT_W-1:0] pay;
        logic                  fixed;
        t_resp                 want;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_mode;
    logic [KEY_W-1:0]          i_key_time;
    logic [PAY_PORT_W-1:0]     i_payload;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [STATUS_W-1:0]       o_status;
    logic signed [TIME_W-1:0]  o_out_time;
    logic [PAY_PORT_W-1:0]     o_out_payload;
    logic                      o_empty_after;

    // Shadow copy of the queue contents, front at index 0.
    logic [KEY_W-1:0]      held_keys [QDEPTH];
    logic [PAY_PORT_W-1:0] held_pays [QDEPTH];
    int                    held = 0;

    t_resp     queued_responses [$];
    t_stim_row dir_rows [DIRECTED_ROWS];
    t_resp     got_resp;
    t_resp     want_resp;
    int        mismatches = 0;
    int        n_push = 0;
    int        n_pop = 0;
    int        n_dropped = 0;
    int        n_empty_pops = 0;
    bit        no_idle = 1'b0;
    int        idle_cycles;

    stable_sorted_priority_queue_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_key_time    (i_key_time),
        .i_payload     (i_payload),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_out_time    (o_out_time),
        .o_out_payload (o_out_payload),
        .o_empty_after (o_empty_after)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_stim_row mk_row(logic m, logic [KEY_W-1:0] k,
                                         logic [PAY_PORT_W-1:0] p, logic fx, t_resp w);
        t_stim_row r;
        r.mode  = m;
        r.key   = k;
        r.pay   = p;
        r.fixed = fx;
        r.want  = w;
        return r;
    endfunction

    // Half the gaps back-to-back, else mostly a short pause, rarely a long one; none while no_idle.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Narrow key ranges produce many ties, which exercise the arrival-order rule.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return KEY_W'($urandom);
        if (r < 7) return KEY_W'($urandom_range(0, 7));
        if (r == 7) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return KEY_W'(16'h8000 + $urandom_range(0, 15) - 8);
    endfunction

    task automatic sorted_queue_apply(input logic m, input logic [KEY_W-1:0] k,
                                      input logic [PAY_PORT_W-1:0] p, output t_resp r);
        int pos;
        r = '0;
        if (m == ssq_pkg::MODE_PUSH) begin
            if (held >= QDEPTH) begin
                r.status = ssq_pkg::ST_FULL_PUSH;
                n_dropped++;
            end else begin
                pos = 0;
                while (pos < held && held_keys[pos] <= k) pos++;
                for (int i = held; i > pos; i--) begin
                    held_keys[i] = held_keys[i-1];
                    held_pays[i] = held_pays[i-1];
                end
                held_keys[pos] = k;
                held_pays[pos] = p & PAY_MASK;
                held++;
                n_push++;
            end
        end else begin
            if (held == 0) begin
                r.status = ssq_pkg::ST_EMPTY_POP;
                r.otime  = -17'sd1;
                n_empty_pops++;
            end else begin
                r.otime = {1'b0, held_keys[0]};
                r.opay  = held_pays[0];
                for (int i = 1; i < held; i++) begin
                    held_keys[i-1] = held_keys[i];
                    held_pays[i-1] = held_pays[i];
                end
                held--;
                n_pop++;
            end
        end
        r.empty = (held == 0);
    endtask

    // Presents one item, holds it until the transfer, then records what it should return.
    task automatic issue(input t_stim_row row);
        t_resp pred;
        int    gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= row.mode;
        i_key_time <= row.key;
        i_payload  <= row.pay;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sorted_queue_apply(row.mode, row.key, row.pay, pred);
        queued_responses.push_back(row.fixed ? row.want : pred);
    endtask

    task automatic log_mismatch(string what, t_resp want, t_resp got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
            $display("%0t: %s: status %0d/%0d time %0d/%0d payload %h/%h empty %0b/%0b",
                     $realtime, what, want.status, got.status, want.otime, got.otime,
                     want.opay, got.opay, want.empty, got.empty);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_resp = '{o_status, o_out_time, o_out_payload, o_empty_after};
            if (queued_responses.size() == 0) begin
                log_mismatch("result with nothing pending (expected/actual)", '0, got_resp);
            end else begin
                want_resp = queued_responses.pop_front();
                if (got_resp.status !== want_resp.status || got_resp.otime !== want_resp.otime
                        || got_resp.opay !== want_resp.opay
                        || got_resp.empty !== want_resp.empty) begin
                    log_mismatch("result differs (expected/actual)", want_resp, got_resp);
                end
            end
        end
    end

    // Result side back-pressure.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        idle_cycles = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, queued_responses.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_stim_row row;
        int        sent;
        int        seg_len;
        int        push_pct;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_mode     = ssq_pkg::MODE_PUSH;
        i_key_time = '0;
        i_payload  = '0;

        // Pops of an empty queue, extreme keys and payloads, a tie, then a fill to the
        // depth limit and one push that must be dropped.
        dir_rows[0]  = mk_row(ssq_pkg::MODE_POP,  16'h0000, 32'h0000_0000, 1'b1,
                              '{ssq_pkg::ST_EMPTY_POP, -17'sd1, 32'd0, 1'b1});
        dir_rows[1]  = mk_row(ssq_pkg::MODE_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                              '{ssq_pkg::ST_OK, 17'sd0, 32'd0, 1'b0});
        dir_rows[2]  = mk_row(ssq_pkg::MODE_PUSH, 16'h0000, 32'h0000_0000, 1'b1,
                              '{ssq_pkg::ST_OK, 17'sd0, 32'd0, 1'b0});
        dir_rows[3]  = mk_row(ssq_pkg::MODE_PUSH, 16'hFFFF, 32'hA5A5_A5A5, 1'b0, '0);
        dir_rows[4]  = mk_row(ssq_pkg::MODE_POP,  16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0);
        dir_rows[5]  = mk_row(ssq_pkg::MODE_POP,  16'h0000, 32'h0000_0000, 1'b0, '0);
        dir_rows[6]  = mk_row(ssq_pkg::MODE_POP,  16'h5555, 32'h5555_5555, 1'b0, '0);
        dir_rows[7]  = mk_row(ssq_pkg::MODE_POP,  16'hAAAA, 32'hAAAA_AAAA, 1'b1,
                              '{ssq_pkg::ST_EMPTY_POP, -17'sd1, 32'd0, 1'b1});
        dir_rows[8]  = mk_row(ssq_pkg::MODE_PUSH, 16'h8000, 32'h5555_5555, 1'b0, '0);
        dir_rows[9]  = mk_row(ssq_pkg::MODE_PUSH, 16'h0001, 32'hAAAA_AAAA, 1'b0, '0);
        dir_rows[10] = mk_row(ssq_pkg::MODE_PUSH, 16'h8000, 32'h0000_0001, 1'b0, '0);
        dir_rows[11] = mk_row(ssq_pkg::MODE_PUSH, 16'h7FFF, 32'h8000_0000, 1'b0, '0);
        dir_rows[12] = mk_row(ssq_pkg::MODE_PUSH, 16'h5555, 32'h1234_5678, 1'b0, '0);
        dir_rows[13] = mk_row(ssq_pkg::MODE_PUSH, 16'hAAAA, 32'h8765_4321, 1'b0, '0);
        dir_rows[14] = mk_row(ssq_pkg::MODE_PUSH, 16'h8000, 32'h0F0F_0F0F, 1'b0, '0);
        dir_rows[15] = mk_row(ssq_pkg::MODE_PUSH, 16'h0001, 32'hF0F0_F0F0, 1'b0, '0);
        dir_rows[16] = mk_row(ssq_pkg::MODE_PUSH, 16'hFFFE, 32'h7FFF_FFFF, 1'b0, '0);
        dir_rows[17] = mk_row(ssq_pkg::MODE_PUSH, 16'h0000, 32'hFFFF_FFFE, 1'b0, '0);
        dir_rows[18] = mk_row(ssq_pkg::MODE_PUSH, 16'h1234, 32'hDEAD_BEEF, 1'b0, '0);
        dir_rows[19] = mk_row(ssq_pkg::MODE_PUSH, 16'h8000, 32'hCAFE_F00D, 1'b0, '0);
        dir_rows[20] = mk_row(ssq_pkg::MODE_PUSH, 16'hFFFF, 32'h0000_FFFF, 1'b0, '0);
        dir_rows[21] = mk_row(ssq_pkg::MODE_PUSH, 16'h0000, 32'hFFFF_0000, 1'b0, '0);
        dir_rows[22] = mk_row(ssq_pkg::MODE_PUSH, 16'h4321, 32'h3C3C_3C3C, 1'b0, '0);
        dir_rows[23] = mk_row(ssq_pkg::MODE_PUSH, 16'h00FF, 32'hC3C3_C3C3, 1'b0, '0);
        dir_rows[24] = mk_row(ssq_pkg::MODE_PUSH, 16'h2222, 32'h1111_1111, 1'b1,
                              '{ssq_pkg::ST_FULL_PUSH, 17'sd0, 32'd0, 1'b0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) issue(dir_rows[r]);

        // Random part in segments, each leaning toward pushes or pops so the queue
        // swings between empty and full; some segments run without any idling.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(10, 50);
            case ($urandom_range(0, 3))
                0: push_pct = 15;
                1: push_pct = 45;
                2: push_pct = 60;
                default: push_pct = 90;
            endcase
            no_idle = ($urandom_range(0, 5) == 0);
            for (int j = 0; j < seg_len && sent < RANDOM_ITEMS; j++) begin
                row = mk_row(($urandom_range(0, 99) < push_pct) ? ssq_pkg::MODE_PUSH
                                                                 : ssq_pkg::MODE_POP,
                             pick_key(), PAY_PORT_W'($urandom), 1'b0, '0);
                issue(row);
                sent++;
            end
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (queued_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d pushes stored, %0d pops returned an entry,",
                 DIRECTED_ROWS + RANDOM_ITEMS, n_push, n_pop);
        $display("%0d pushes dropped on a full queue, %0d pops of an empty queue",
                 n_dropped, n_empty_pops);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* stable_sorted_priority_queue_unit.f */
sv/ssq_pkg.sv
sv/ssq_mem.sv
sv/ssq_ctrl.sv
sv/stable_sorted_priority_queue_unit.sv
tb/tb_stable_sorted_priority_queue_unit.sv
